// ----- hw/rtl/fm_oscillator_waveshaper_defines.svh -----
// Assertion macros shared by the oscillator RTL.
// Depends on nothing; files that assert include it and provide clk and rst.
`ifndef FM_OSCILLATOR_WAVESHAPER_DEFINES_SVH
`define FM_OSCILLATOR_WAVESHAPER_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define FMOW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define FMOW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/fmow_pkg.sv -----
// Package for the FM oscillator: sequencer states, waveform codes, constants.
// Depends on nothing.
`default_nettype none

package fmow_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FM,
    S_ACC,
    S_SQR,
    S_OUT
  } fmow_state_t;

  typedef enum logic [1:0] {
    SEL_SQUARE = 2'b00,
    SEL_SAW    = 2'b01,
    SEL_SINE   = 2'b10,
    SEL_TRI    = 2'b11
  } wave_sel_t;

  localparam int PHASE_W = 32;
  localparam int SAMPLE_W = 16;
  localparam int FM_SHIFT = 15;
  localparam int SQ_SHIFT = 15;

  // Operand width of the shared multiplier: a signed 16-bit depth times a
  // 17-bit increment, or a 16-bit distance squared.
  localparam int MUL_W = 18;
  localparam int PROD_W = 2 * MUL_W;

  // Shaping arithmetic is done at 18 bits signed.
  localparam logic signed [17:0] W_FULL    = 18'sd32767;
  localparam logic signed [17:0] W_QUARTER = 18'sd16384;
  localparam logic signed [17:0] W_SPAN    = 18'sd65535;

endpackage

`default_nettype wire

// ----- hw/rtl/fmow_tick_if.sv -----
// Input channel of the oscillator: one beat is one sample tick.
// Depends on nothing.
`default_nettype none

interface fmow_tick_if;
  logic               valid;
  logic               ready;
  logic        [31:0] phase_incr;
  logic signed [15:0] fm_depth;
  logic signed [15:0] waveform;

  modport source (output valid, output phase_incr, output fm_depth, output waveform,
                  input ready);
  modport sink   (input valid, input phase_incr, input fm_depth, input waveform,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/fmow_wave_if.sv -----
// Output channel of the oscillator: one beat is one shaped sample.
// Depends on nothing.
`default_nettype none

interface fmow_wave_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/fmow_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on fmow_pkg for the operand width.
`default_nettype none

module fmow_mul (
  input  logic                                clk,
  input  logic signed [fmow_pkg::MUL_W-1:0]   a,
  input  logic signed [fmow_pkg::MUL_W-1:0]   b,
  output logic signed [fmow_pkg::PROD_W-1:0]  p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/fm_oscillator_waveshaper.sv -----
// FM oscillator top level: phase accumulator, sequencer and waveform shaper.
// Depends on fmow_pkg, fmow_tick_if, fmow_wave_if, fmow_mul and the defines header.
//
// Usage:
//   tick (sink): one beat per audio sample carries phase_incr, fm_depth and
//   waveform. wave (source): one beat of sample per accepted tick, in order.
//   A tick is taken only while the sequencer is idle. The single multiplier
//   first forms fm_depth * (phase_incr >> 15), the accumulator then adds the
//   increment and that term, and the multiplier is used again to square the
//   distance for the parabolic sine. The sample is registered on wave in the
//   output step, after the FM, accumulate and square steps; the sequencer
//   then goes idle: a new tick is taken once the last is loaded, while wave drains.
//   If the receiver stalls, the result waits in the output register; the
//   next tick is still accepted and processed, and holds in its last step
//   until the output register is free.
//   Reset (rst, synchronous) clears the accumulator, drops wave.valid and
//   returns the sequencer to idle; tick.ready stays low while rst is high.
`default_nettype none
`include "fm_oscillator_waveshaper_defines.svh"

module fm_oscillator_waveshaper (
  input  logic               clk,
  input  logic               rst,
  fmow_tick_if.sink          tick,
  fmow_wave_if.source        wave
);

  fmow_pkg::fmow_state_t state, state_next;

  logic        [31:0]                     incr;
  logic signed [15:0]                     fm;
  fmow_pkg::wave_sel_t                    sel;
  logic        [fmow_pkg::PHASE_W-1:0]    phase_acc;

  logic signed [fmow_pkg::MUL_W-1:0]      mul_a;
  logic signed [fmow_pkg::MUL_W-1:0]      mul_b;
  logic signed [fmow_pkg::PROD_W-1:0]     prod;

  logic signed [17:0] saw;
  logic signed [17:0] tri_t;
  logic signed [17:0] tri_v;
  logic signed [17:0] gap;
  logic signed [17:0] sq;
  logic signed [17:0] shaped;
  logic               tick_acc;
  logic               out_load;

  assign tick.ready = (state == fmow_pkg::S_IDLE) && !rst;
  assign tick_acc   = tick.valid && tick.ready;
  assign out_load   = (state == fmow_pkg::S_OUT) && (!wave.valid || wave.ready);

  // Saw, triangle and sine distance all follow from the settled accumulator.
  always_comb begin
    saw   = $signed({2'b00, phase_acc[31:16]}) - fmow_pkg::W_FULL;
    tri_t = saw - fmow_pkg::W_QUARTER;
    if (tri_t < -fmow_pkg::W_FULL) begin
      tri_t = tri_t + fmow_pkg::W_SPAN;
    end
    if (tri_t > 18'sd0) begin
      tri_t = -tri_t;
    end
    tri_v = (tri_t <<< 1) + fmow_pkg::W_FULL;
    if (tri_v > 18'sd0) begin
      gap = fmow_pkg::W_FULL - tri_v;
    end else begin
      gap = fmow_pkg::W_FULL + tri_v;
    end
  end

  // The multiplier squares the distance in the last two steps and forms the
  // FM term otherwise; its product is registered, so it appears in the next cycle.
  always_comb begin
    if (state == fmow_pkg::S_SQR || state == fmow_pkg::S_OUT) begin
      mul_a = gap;
      mul_b = gap;
    end else begin
      mul_a = fmow_pkg::MUL_W'(fm);
      mul_b = $signed({1'b0, incr[31:fmow_pkg::FM_SHIFT]});
    end
  end

  fmow_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  always_comb begin
    // The square is below 2^30, so the shifted value fits in 15 bits.
    sq = $signed({3'b000, prod[29:fmow_pkg::SQ_SHIFT]});
    unique case (sel)
      fmow_pkg::SEL_SQUARE: shaped = (saw > 18'sd0) ? fmow_pkg::W_FULL : -fmow_pkg::W_FULL;
      fmow_pkg::SEL_SAW:    shaped = saw;
      fmow_pkg::SEL_SINE:   shaped = (tri_v > 18'sd0) ? (fmow_pkg::W_FULL - sq)
                                                      : (sq - fmow_pkg::W_FULL);
      fmow_pkg::SEL_TRI:    shaped = tri_v;
      default:              shaped = saw;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fmow_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fmow_pkg::S_IDLE: if (tick_acc) state_next = fmow_pkg::S_FM;
      fmow_pkg::S_FM:   state_next = fmow_pkg::S_ACC;
      fmow_pkg::S_ACC:  state_next = fmow_pkg::S_SQR;
      fmow_pkg::S_SQR:  state_next = fmow_pkg::S_OUT;
      fmow_pkg::S_OUT:  if (out_load) state_next = fmow_pkg::S_IDLE;
      default:          state_next = fmow_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      incr <= tick.phase_incr;
      fm   <= tick.fm_depth;
      sel  <= fmow_pkg::wave_sel_t'(tick.waveform[15:14]);
    end
  end

  // A zero depth gives a zero product, so the FM term is always added.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
    end else if (state == fmow_pkg::S_ACC) begin
      phase_acc <= phase_acc + incr + prod[fmow_pkg::PHASE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave.valid <= 1'b0;
    end else if (out_load) begin
      wave.valid <= 1'b1;
    end else if (wave.ready) begin
      wave.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      wave.sample <= shaped[fmow_pkg::SAMPLE_W-1:0];
    end
  end

  `FMOW_ASSERT(a_tick_starts_fm, tick_acc |=> state == fmow_pkg::S_FM, "tick beat did not start the sequence")
  `FMOW_ASSERT_ALWAYS(a_reset_clears, rst |=> !wave.valid && state == fmow_pkg::S_IDLE, "reset left output or sequencer busy")
  `FMOW_ASSERT(a_acc_only_in_step, state != fmow_pkg::S_ACC |=> $stable(phase_acc), "accumulator moved outside its step")
  `FMOW_ASSERT(a_out_from_last_step, $rose(wave.valid) |-> $past(state) == fmow_pkg::S_OUT, "sample beat raised outside the output step")

endmodule

`default_nettype wire

// ----- tb/osc_scoreboard_pkg.sv -----
// Scoreboard for the FM oscillator testbench: it predicts each sample and checks it.
// Depends on fmow_pkg for the waveform selector codes.
`timescale 1ns / 100ps

package osc_scoreboard_pkg;
  import fmow_pkg::*;

  localparam int FULL_SCALE = 32767;
  localparam int QUARTER = 16384;
  localparam int SPAN = 65535;
  localparam int SQ_DROP = 15;
  localparam int FM_DROP = 15;

  class osc_scoreboard;
    bit [31:0]          phase;
    logic signed [15:0] sample_q[$];
    int                 errors;

    function new();
      phase = '0;
      errors = 0;
    endfunction

    function int tri_wave(int saw);
      int t;
      t = saw - QUARTER;
      if (t < -FULL_SCALE) t += SPAN;
      if (t > 0) t = -t;
      return 2 * t + FULL_SCALE;
    endfunction

    function logic signed [15:0] shape(int saw, wave_sel_t sel);
      int v;
      int d;
      int y;
      case (sel)
        SEL_SQUARE: y = (saw > 0) ? FULL_SCALE : -FULL_SCALE;
        SEL_SAW:    y = saw;
        SEL_SINE: begin
          v = tri_wave(saw);
          // Parabola bent toward the peak on each half of the triangle.
          if (v > 0) begin
            d = FULL_SCALE - v;
            y = FULL_SCALE - ((d * d) >>> SQ_DROP);
          end else begin
            d = FULL_SCALE + v;
            y = ((d * d) >>> SQ_DROP) - FULL_SCALE;
          end
        end
        default:    y = tri_wave(saw);
      endcase
      // The top saw value wraps to the most negative sample.
      return y[15:0];
    endfunction

    function void note_tick(bit [31:0] incr, bit [15:0] fm, bit [15:0] wf);
      bit [31:0] fm_wide;
      bit [31:0] fm_term;
      int        saw;
      phase = phase + incr;
      if (fm != 16'd0) begin
        fm_wide = {{16{fm[15]}}, fm};
        fm_term = fm_wide * (incr >> FM_DROP);
        phase = phase + fm_term;
      end
      saw = int'(phase[31:16]) - FULL_SCALE;
      sample_q.push_back(shape(saw, wave_sel_t'(wf[15:14])));
    endfunction

    function int pending();
      return sample_q.size();
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_sample(logic signed [15:0] got);
      logic signed [15:0] want;
      if (sample_q.size() == 0) begin
        report($sformatf("sample %0d arrived with no tick outstanding", got));
      end else begin
        want = sample_q.pop_front();
        if (got !== want)
          report($sformatf("sample got %0d, expected %0d", got, want));
      end
    endtask
  endclass

endpackage

// ----- tb/tb_top.sv -----
// Top of the FM oscillator testbench: clock, reset, tick driver and wave receiver.
// Depends on fmow_pkg, the two channel interfaces and osc_scoreboard_pkg.
`timescale 1ns / 100ps

module tb_top;
  import osc_scoreboard_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_TICKS = 1550;
  localparam int QUIET_TICKS = 150;
  localparam int HOLD_CYCLES = 400;

  logic clk;
  logic rst;

  fmow_tick_if tick_bus ();
  fmow_wave_if wave_bus ();

  fm_oscillator_waveshaper dut (
    .clk  (clk),
    .rst  (rst),
    .tick (tick_bus),
    .wave (wave_bus)
  );

  osc_scoreboard sb = new();

  bit quiet;
  bit hold_req;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: checks each accepted beat, then picks ready for the next edge.
  initial begin
    int stall_left;
    stall_left = 0;
    wave_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && wave_bus.valid && wave_bus.ready) sb.check_sample(wave_bus.sample);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 8);
      end
      wave_bus.ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  task automatic send_tick(input bit [31:0] incr, input bit [15:0] fm, input bit [15:0] wf);
    tick_bus.valid <= 1'b1;
    tick_bus.phase_incr <= incr;
    tick_bus.fm_depth <= fm;
    tick_bus.waveform <= wf;
    do begin
      @(posedge clk);
    end while (!tick_bus.ready);
    sb.note_tick(incr, fm, wf);
  endtask

  task automatic pause_ticks(input int cycles);
    tick_bus.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_samples();
    tick_bus.valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (sb.pending() != 0);
  endtask

  task automatic send_random_tick();
    bit [31:0] incr;
    bit [15:0] fm;
    int        pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) incr = $urandom();
    else if (pick < 70) incr = $urandom_range(0, 32'h00FF_FFFF);
    else if (pick < 85) incr = 32'hFFFF_FFFF - $urandom_range(0, 32'h0FFF_FFFF);
    else incr = $urandom_range(32'h0001_0000, 32'h0400_0000);
    pick = $urandom_range(0, 99);
    if (pick < 40) fm = 16'd0;
    else if (pick < 70) fm = 16'($urandom());
    else fm = 16'($signed($urandom_range(0, 128)) - 64);
    send_tick(incr, fm, 16'($urandom()));
  endtask

  initial begin
    rst <= 1'b1;
    tick_bus.valid <= 1'b0;
    tick_bus.phase_incr <= '0;
    tick_bus.fm_depth <= '0;
    tick_bus.waveform <= '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed beats: shape corners, saw wraparound, triangle fold points,
    // extreme increments and FM depths, and FM sums that wrap.
    send_tick(32'h0000_0000, 16'h0000, 16'h0000);
    send_tick(32'hFFFF_0000, 16'h0000, 16'h4000);
    send_tick(32'h0001_0000, 16'h0000, 16'h8000);
    send_tick(32'h4000_0000, 16'h0000, 16'hC000);
    send_tick(32'h4000_0000, 16'h0000, 16'h8000);
    send_tick(32'h4000_0000, 16'h0000, 16'hC000);
    send_tick(32'h3FFF_FFFF, 16'h0000, 16'h0000);
    send_tick(32'hFFFF_FFFF, 16'h0000, 16'h7FFF);
    send_tick(32'hFFFF_FFFF, 16'h8000, 16'hBFFF);
    send_tick(32'hFFFF_FFFF, 16'h7FFF, 16'hFFFF);
    send_tick(32'h0000_7FFF, 16'h04D2, 16'h4000);
    send_tick(32'h0000_8000, 16'hFFFF, 16'h0000);
    send_tick(32'h1234_5678, 16'h0001, 16'h8000);
    send_tick(32'h0010_0000, 16'h8000, 16'h4000);
    send_tick(32'h0010_0000, 16'h7FFF, 16'hC000);
    send_tick(32'h8000_0000, 16'h0000, 16'h8000);
    send_tick(32'h8000_0000, 16'hFFFF, 16'h3FFF);
    send_tick(32'h0001_0000, 16'h0000, 16'h4000);
    send_tick(32'hFFFF_0000, 16'h0000, 16'h8000);
    send_tick(32'hFFFF_0000, 16'h0000, 16'hC000);
    drain_samples();

    for (int n = 0; n < RANDOM_TICKS; n++) begin
      if (n == RANDOM_TICKS - QUIET_TICKS) quiet = 1'b1;
      // A long receiver stall while ticks keep coming backs the block up.
      if (n == 300) hold_req = 1'b1;
      if (n == 700) drain_samples();
      else if (!quiet && $urandom_range(0, 5) == 0) pause_ticks($urandom_range(1, 8));
      send_random_tick();
    end
    tick_bus.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
